[rtl/ghsa_pkg.sv]
// ----------------------------------------------------------------------------
// ghsa_pkg
// Shared types, constants and helpers of the generational handle allocator.
// ----------------------------------------------------------------------------
package ghsa_pkg;

	localparam int SLOT_COUNT_DEF   = 64;
	localparam int TEXTURE_BITS_DEF = 32;

	localparam int CMD_W       = 2;
	localparam int HANDLE_W    = 7;
	localparam int GEN_W       = 32;
	localparam int TEX_FIELD_W = 32;

	localparam int FIELDS_W   = HANDLE_W + GEN_W + TEX_FIELD_W;
	localparam int TDATA_W    = ((FIELDS_W + 7) / 8) * 8;
	localparam int TDATA_PAD  = TDATA_W - FIELDS_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_CREATE      = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DESTROY     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESOLVE     = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DESTROY_ALL = 2'd3;

	typedef enum logic [2:0] {
		K_CREATE,
		K_DESTROY,
		K_RESOLVE,
		K_ALL,
		K_FAIL
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [HANDLE_W-1:0]    index;
		logic [GEN_W-1:0]       gen;
		logic [TEX_FIELD_W-1:0] tex;
	} op_t;

	typedef struct packed {
		logic                   ok;
		logic [HANDLE_W-1:0]    index;
		logic [GEN_W-1:0]       gen;
		logic [TEX_FIELD_W-1:0] tex;
		logic                   last;
	} res_t;

	// generation advance, skipping zero
	function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
		logic [GEN_W-1:0] n;
		n = g + GEN_W'(1);
		return (n == '0) ? GEN_W'(1) : n;
	endfunction

endpackage

[rtl/ghsa_front.sv]
// ----------------------------------------------------------------------------
// ghsa_front
// Accepts commands and classifies them, marking null textures and
// out-of-range handles as failures before they reach the slot engine.
// ----------------------------------------------------------------------------
module ghsa_front #(
	parameter int SLOT_COUNT   = ghsa_pkg::SLOT_COUNT_DEF,
	parameter int TEXTURE_BITS = ghsa_pkg::TEXTURE_BITS_DEF
) (
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ghsa_pkg::CMD_W-1:0]          command,
	input  logic [ghsa_pkg::HANDLE_W-1:0]       handle_index,
	input  logic [ghsa_pkg::GEN_W-1:0]          handle_generation,
	input  logic [ghsa_pkg::TEX_FIELD_W-1:0]    native_texture,
	output logic                                push_valid,
	input  logic                                push_ready,
	output ghsa_pkg::op_t                       push_data
);
	import ghsa_pkg::*;

	localparam int TEX_W = (TEXTURE_BITS < TEX_FIELD_W) ? TEXTURE_BITS : TEX_FIELD_W;

	logic [TEX_W-1:0] tex_masked;
	logic             bad_index;
	kind_t            kind;

	assign tex_masked = TEX_W'(native_texture);
	assign bad_index  = (handle_index == '0) || (handle_index > HANDLE_W'(SLOT_COUNT));

	always_comb begin
		unique case (command)
			CMD_CREATE:      kind = (tex_masked == '0) ? K_FAIL : K_CREATE;
			CMD_DESTROY:     kind = bad_index ? K_FAIL : K_DESTROY;
			CMD_RESOLVE:     kind = bad_index ? K_FAIL : K_RESOLVE;
			CMD_DESTROY_ALL: kind = K_ALL;
			default:         kind = K_FAIL;
		endcase
	end

	assign in_ready         = push_ready;
	assign push_valid       = in_valid;
	assign push_data.kind   = kind;
	assign push_data.index  = handle_index;
	assign push_data.gen    = handle_generation;
	assign push_data.tex    = TEX_FIELD_W'(tex_masked);

endmodule

[rtl/ghsa_queue.sv]
// ----------------------------------------------------------------------------
// ghsa_queue
// Short command queue between the classifier and the slot engine.
// ----------------------------------------------------------------------------
module ghsa_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  ghsa_pkg::op_t  push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output ghsa_pkg::op_t  pop_data
);
	import ghsa_pkg::*;

	op_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/ghsa_back.sv]
// ----------------------------------------------------------------------------
// ghsa_back
// Slot engine: owns the slot tables and free stack, executes one command at a
// time and drives the result register.
// ----------------------------------------------------------------------------
module ghsa_back #(
	parameter int SLOT_COUNT   = ghsa_pkg::SLOT_COUNT_DEF,
	parameter int TEXTURE_BITS = ghsa_pkg::TEXTURE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  ghsa_pkg::op_t  q_data,
	output logic           res_valid,
	input  logic           res_ready,
	output ghsa_pkg::res_t res_data
);
	import ghsa_pkg::*;

	localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
	localparam int TEX_W   = (TEXTURE_BITS < TEX_FIELD_W) ? TEXTURE_BITS : TEX_FIELD_W;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_FAIL    = 8'b0000_0010,
		S_POP     = 8'b0000_0100,
		S_CREATE  = 8'b0000_1000,
		S_LOOK    = 8'b0001_0000,
		S_ALL_RD  = 8'b0010_0000,
		S_ALL_WR  = 8'b0100_0000,
		S_ALL_END = 8'b1000_0000
	} state_t;

	// slot memories
	logic [GEN_W-1:0]    gen_mem [SLOT_COUNT];
	logic [TEX_W-1:0]    tex_mem [SLOT_COUNT];
	logic [HANDLE_W-1:0] stk_mem [SLOT_COUNT];
	logic [GEN_W-1:0]    gen_rd_q;
	logic [TEX_W-1:0]    tex_rd_q;
	logic [HANDLE_W-1:0] stk_rd_q;

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      su_q, su_d;
	logic [CNT_W-1:0]      fd_q, fd_d;
	logic [SLOT_COUNT-1:0] ready_q, ready_d;
	logic [SLOT_AW-1:0]    p_q, p_d;
	logic                  fresh_q, fresh_d;
	logic                  none_q, none_d;
	op_t                   op_q;
	logic                  out_valid_q;
	res_t                  res_q, res_d;

	logic                  can_emit;
	logic                  emit;
	logic                  pop;
	logic                  gen_re, tex_re, stk_re;
	logic                  gen_we, tex_we, stk_we;
	logic [SLOT_AW-1:0]    rd_addr, wr_addr, stk_ra, stk_wa;
	logic [GEN_W-1:0]      gen_wd;
	logic [HANDLE_W-1:0]   stk_wd;
	logic                  hit;
	logic                  more_ready;

	assign can_emit   = !out_valid_q || res_ready;
	assign q_ready    = (state_q == S_IDLE);
	assign pop        = q_valid && q_ready;
	assign hit        = ready_q[p_q] && (gen_rd_q == op_q.gen);
	// any ready slot above the sweep position
	assign more_ready = |((ready_q >> p_q) >> 1);

	always_comb begin
		state_d = state_q;
		su_d    = su_q;
		fd_d    = fd_q;
		ready_d = ready_q;
		p_d     = p_q;
		fresh_d = fresh_q;
		none_d  = none_q;
		emit    = 1'b0;
		res_d   = '{ok: 1'b0, index: '0, gen: '0, tex: '0, last: 1'b1};
		gen_re  = 1'b0;
		tex_re  = 1'b0;
		stk_re  = 1'b0;
		gen_we  = 1'b0;
		tex_we  = 1'b0;
		stk_we  = 1'b0;
		rd_addr = p_q;
		wr_addr = p_q;
		stk_ra  = SLOT_AW'(fd_q - 1'b1);
		stk_wa  = SLOT_AW'(fd_q);
		gen_wd  = next_gen(gen_rd_q);
		stk_wd  = HANDLE_W'(p_q) + HANDLE_W'(1);

		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					unique case (q_data.kind)
						K_CREATE: begin
							if (fd_q != '0) begin
								stk_re  = 1'b1;
								fd_d    = fd_q - 1'b1;
								state_d = S_POP;
							end else if (su_q != CNT_W'(SLOT_COUNT)) begin
								p_d     = SLOT_AW'(su_q);
								su_d    = su_q + 1'b1;
								fresh_d = 1'b1;
								state_d = S_CREATE;
							end else begin
								state_d = S_FAIL;
							end
						end
						K_DESTROY, K_RESOLVE: begin
							if (q_data.index <= HANDLE_W'(su_q)) begin
								p_d     = SLOT_AW'(q_data.index - HANDLE_W'(1));
								rd_addr = SLOT_AW'(q_data.index - HANDLE_W'(1));
								gen_re  = 1'b1;
								tex_re  = 1'b1;
								state_d = S_LOOK;
							end else begin
								state_d = S_FAIL;
							end
						end
						K_ALL: begin
							none_d  = ~|ready_q;
							p_d     = '0;
							state_d = (su_q == '0) ? S_ALL_END : S_ALL_RD;
						end
						default: state_d = S_FAIL;
					endcase
				end
			end
			S_POP: begin
				// popped index now addresses the generation table
				p_d     = SLOT_AW'(stk_rd_q - HANDLE_W'(1));
				rd_addr = SLOT_AW'(stk_rd_q - HANDLE_W'(1));
				gen_re  = 1'b1;
				fresh_d = 1'b0;
				state_d = S_CREATE;
			end
			S_CREATE: begin
				if (can_emit) begin
					emit        = 1'b1;
					res_d.ok    = 1'b1;
					res_d.index = HANDLE_W'(p_q) + HANDLE_W'(1);
					res_d.gen   = fresh_q ? GEN_W'(1) : gen_rd_q;
					tex_we      = 1'b1;
					gen_we      = fresh_q;
					gen_wd      = GEN_W'(1);
					ready_d[p_q] = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_LOOK: begin
				if (can_emit) begin
					emit      = 1'b1;
					res_d.ok  = hit;
					res_d.tex = hit ? TEX_FIELD_W'(tex_rd_q) : '0;
					if (hit && (op_q.kind == K_DESTROY)) begin
						ready_d[p_q] = 1'b0;
						gen_we       = 1'b1;
						stk_we       = 1'b1;
						fd_d         = fd_q + 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_ALL_RD: begin
				gen_re  = 1'b1;
				tex_re  = 1'b1;
				state_d = S_ALL_WR;
			end
			S_ALL_WR: begin
				if (!ready_q[p_q] || can_emit) begin
					emit       = ready_q[p_q];
					res_d.ok   = 1'b1;
					res_d.tex  = TEX_FIELD_W'(tex_rd_q);
					res_d.last = !more_ready;
					ready_d[p_q] = 1'b0;
					gen_we     = 1'b1;
					stk_we     = 1'b1;
					stk_wa     = p_q;
					if ((HANDLE_W'(p_q) + HANDLE_W'(1)) == HANDLE_W'(su_q)) begin
						fd_d    = su_q;
						state_d = S_ALL_END;
					end else begin
						p_d     = SLOT_AW'(p_q + 1'b1);
						state_d = S_ALL_RD;
					end
				end
			end
			S_ALL_END: begin
				// empty sweep still answers once
				if (!none_q) begin
					state_d = S_IDLE;
				end else if (can_emit) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FAIL: begin
				if (can_emit) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			su_q        <= '0;
			fd_q        <= '0;
			ready_q     <= '0;
			p_q         <= '0;
			fresh_q     <= 1'b0;
			none_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			su_q    <= su_d;
			fd_q    <= fd_d;
			ready_q <= ready_d;
			p_q     <= p_d;
			fresh_q <= fresh_d;
			none_q  <= none_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= q_data;
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_we) begin
			gen_mem[wr_addr] <= gen_wd;
		end
		if (gen_re) begin
			gen_rd_q <= gen_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (tex_we) begin
			tex_mem[wr_addr] <= TEX_W'(op_q.tex);
		end
		if (tex_re) begin
			tex_rd_q <= tex_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[stk_ra];
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = res_q;

endmodule

[rtl/generational_handle_slot_allocator_core.sv]
// Generational handle slot allocator. Commands enter a two-entry queue and
// are executed one at a time by a slot engine that reads and writes its
// generation, texture and free-stack memories (one read and one write port
// each, registered read data). In the engine a create that appends a slot
// runs S_CREATE, a rejected command S_FAIL, a destroy and a resolve S_LOOK;
// a create that reuses a freed slot runs S_POP first, since the popped index
// must then address the generation memory. Destroy-all reads each appended
// slot in S_ALL_RD and clears it in S_ALL_WR, and emits one result per ready
// slot in index order (or a single failure result when none is ready). A
// result register on the output lets the engine finish while a result waits,
// and a stalled output holds the engine only when it has a new result.
// ----------------------------------------------------------------------------
// generational_handle_slot_allocator_core
// Top level: stream ports, command classifier, queue and slot engine.
// ----------------------------------------------------------------------------
module generational_handle_slot_allocator_core #(
	parameter int SLOT_COUNT   = ghsa_pkg::SLOT_COUNT_DEF,
	parameter int TEXTURE_BITS = ghsa_pkg::TEXTURE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// handle_index, handle_generation, native_texture, zero fill
	input  logic [ghsa_pkg::TDATA_W-1:0]  s_axis_tdata,
	// command
	input  logic [ghsa_pkg::CMD_W-1:0]    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_index, out_generation, texture_value, zero fill
	output logic [ghsa_pkg::TDATA_W-1:0]  m_axis_tdata,
	// ok
	output logic                          m_axis_tuser,
	output logic                          m_axis_tlast
);
	import ghsa_pkg::*;

	localparam int GEN_LO = HANDLE_W;
	localparam int TEX_LO = HANDLE_W + GEN_W;

	op_t  push_op;
	op_t  pop_op;
	res_t res;
	logic push_valid, push_ready;
	logic pop_valid, pop_ready;

	ghsa_front #(
		.SLOT_COUNT   (SLOT_COUNT),
		.TEXTURE_BITS (TEXTURE_BITS)
	) u_front (
		.in_valid          (s_axis_tvalid),
		.in_ready          (s_axis_tready),
		.command           (s_axis_tuser),
		.handle_index      (s_axis_tdata[HANDLE_W-1:0]),
		.handle_generation (s_axis_tdata[GEN_LO +: GEN_W]),
		.native_texture    (s_axis_tdata[TEX_LO +: TEX_FIELD_W]),
		.push_valid        (push_valid),
		.push_ready        (push_ready),
		.push_data         (push_op)
	);

	ghsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_op)
	);

	ghsa_back #(
		.SLOT_COUNT   (SLOT_COUNT),
		.TEXTURE_BITS (TEXTURE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_ready   (pop_ready),
		.q_data    (pop_op),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_data  (res)
	);

	assign m_axis_tdata = {{TDATA_PAD{1'b0}}, res.tex, res.gen, res.index};
	assign m_axis_tuser = res.ok;
	assign m_axis_tlast = res.last;

endmodule

[tb/sv/tb_generational_handle_slot_allocator_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_generational_handle_slot_allocator_core
// Self-checking bench for the handle allocator: a local slot table predicts
// every result of create, destroy, resolve and destroy-all commands, and each
// output transaction is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_generational_handle_slot_allocator_core;

	import ghsa_pkg::*;

	localparam int SLOTS = SLOT_COUNT_DEF;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// handle_index, handle_generation, native_texture, zero fill
	logic [TDATA_W-1:0]     s_axis_tdata;
	// command
	logic [CMD_W-1:0]       s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// out_index, out_generation, texture_value, zero fill
	logic [TDATA_W-1:0]     m_axis_tdata;
	// ok
	logic                   m_axis_tuser;
	logic                   m_axis_tlast;

	generational_handle_slot_allocator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// local copy of the slot table
	int               used_cnt;
	int               free_cnt;
	logic [HANDLE_W-1:0] free_idx [SLOTS];
	bit               slot_live [SLOTS];
	logic [GEN_W-1:0] slot_gen [SLOTS];
	logic [TEX_FIELD_W-1:0] slot_tex [SLOTS];

	res_t awaited_results [$];
	res_t got_res;
	res_t want_res;

	int  faults;
	int  results_checked;
	int  cmd_count [4];
	bit  steady;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_CREATE;
		m_axis_tready = 1'b0;
		steady = 1'b0;
		faults = 0;
		results_checked = 0;
		used_cnt = 0;
		free_cnt = 0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_gen[i] = '0;
			slot_tex[i] = '0;
			free_idx[i] = '0;
		end
		for (int i = 0; i < 4; i++)
			cmd_count[i] = 0;
	end

	always #5 clk = ~clk;

	// applies one accepted command to the local table and queues its results
	function automatic void apply_to_table(input logic [CMD_W-1:0] cmd,
		input logic [HANDLE_W-1:0] idx, input logic [GEN_W-1:0] gen,
		input logic [TEX_FIELD_W-1:0] tex);
		res_t r;
		res_t held;
		bit   have_held;
		int   p;
		r = '0;
		r.last = 1'b1;
		held = '0;
		have_held = 1'b0;
		p = -1;
		case (cmd)
		CMD_CREATE: begin
			if (tex != '0) begin
				if (free_cnt > 0) begin
					free_cnt--;
					p = int'(free_idx[free_cnt]) - 1;
				end else if (used_cnt < SLOTS) begin
					p = used_cnt;
					used_cnt++;
					slot_gen[p] = 1;
				end
				if (p >= 0) begin
					if (slot_gen[p] == '0)
						slot_gen[p] = 1;
					slot_live[p] = 1'b1;
					slot_tex[p] = tex;
					r.ok = 1'b1;
					r.index = HANDLE_W'(p + 1);
					r.gen = slot_gen[p];
				end
			end
			awaited_results = {awaited_results, r};
		end
		CMD_DESTROY, CMD_RESOLVE: begin
			if (idx != '0 && int'(idx) <= used_cnt && slot_live[idx - 1] &&
				slot_gen[idx - 1] == gen) begin
				p = int'(idx) - 1;
				r.ok = (slot_tex[p] != '0);
				r.tex = slot_tex[p];
				if (cmd == CMD_DESTROY) begin
					slot_live[p] = 1'b0;
					slot_tex[p] = '0;
					slot_gen[p] = slot_gen[p] + 1'b1;
					if (slot_gen[p] == '0)
						slot_gen[p] = 1;
					if (free_cnt < SLOTS) begin
						free_idx[free_cnt] = HANDLE_W'(p + 1);
						free_cnt++;
					end
				end
			end
			awaited_results = {awaited_results, r};
		end
		default: begin
			// one result per ready slot, last flag on the final one
			for (int i = 0; i < used_cnt; i++) begin
				if (slot_live[i] && slot_tex[i] != '0) begin
					if (have_held)
						awaited_results = {awaited_results, held};
					held = '0;
					held.ok = 1'b1;
					held.tex = slot_tex[i];
					have_held = 1'b1;
				end
				slot_live[i] = 1'b0;
				slot_tex[i] = '0;
				slot_gen[i] = slot_gen[i] + 1'b1;
				if (slot_gen[i] == '0)
					slot_gen[i] = 1;
				free_idx[i] = HANDLE_W'(i + 1);
			end
			free_cnt = used_cnt;
			if (have_held) begin
				held.last = 1'b1;
				awaited_results = {awaited_results, held};
			end else begin
				awaited_results = {awaited_results, r};
			end
		end
		endcase
	endfunction

	function automatic logic [TEX_FIELD_W-1:0] rand_texture();
		logic [TEX_FIELD_W-1:0] t;
		t = $urandom;
		if (t == '0)
			t = 1;
		return t;
	endfunction

	// public index of a random ready slot, 0 if none
	function automatic int pick_live();
		int cand [$];
		for (int i = 0; i < used_cnt; i++)
			if (slot_live[i])
				cand = {cand, i + 1};
		if (cand.size() == 0)
			return 0;
		return cand[$urandom_range(cand.size() - 1)];
	endfunction

	// called at a falling edge; returns at a falling edge with tvalid possibly
	// still high so back-to-back transactions need no second assignment
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] idx,
		input logic [GEN_W-1:0] gen, input logic [TEX_FIELD_W-1:0] tex);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {{TDATA_PAD{1'b0}}, tex, gen, idx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		apply_to_table(cmd, idx, gen, tex);
		cmd_count[cmd]++;
		@(negedge clk);
		if (!steady && $urandom_range(99) < 14) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1))
				@(negedge clk);
		end
	endtask

	task automatic flag_fault(input string why, input res_t want, input res_t got);
		faults++;
		if (faults <= 10) begin
			$write("%0t: %s: expected ok=%0b idx=%0d gen=%h tex=%h last=%0b, ",
				$realtime, why, want.ok, want.index, want.gen, want.tex, want.last);
			$display("got ok=%0b idx=%0d gen=%h tex=%h last=%0b",
				got.ok, got.index, got.gen, got.tex, got.last);
		end
	endtask

	always @(negedge clk)
		m_axis_tready <= steady || ($urandom_range(99) >= 14);

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_res.ok = m_axis_tuser;
			got_res.index = m_axis_tdata[HANDLE_W-1:0];
			got_res.gen = m_axis_tdata[HANDLE_W+GEN_W-1:HANDLE_W];
			got_res.tex = m_axis_tdata[FIELDS_W-1:HANDLE_W+GEN_W];
			got_res.last = m_axis_tlast;
			results_checked++;
			if (awaited_results.size() == 0) begin
				flag_fault("result with nothing awaited", '0, got_res);
			end else begin
				want_res = awaited_results.pop_front();
				if (got_res.ok !== want_res.ok || got_res.index !== want_res.index ||
					got_res.gen !== want_res.gen || got_res.tex !== want_res.tex ||
					got_res.last !== want_res.last)
					flag_fault("result differs", want_res, got_res);
			end
		end
	end

	// null, stale, out-of-range and LIFO reuse cases on a small table
	task automatic test_directed();
		send_cmd(CMD_DESTROY_ALL, '0, '0, '0);
		send_cmd(CMD_CREATE, '0, '0, '0);
		send_cmd(CMD_RESOLVE, '0, '0, '0);
		send_cmd(CMD_CREATE, '0, '0, 32'hFFFF_FFFF);
		send_cmd(CMD_CREATE, '0, '0, 32'h0000_0001);
		send_cmd(CMD_CREATE, 7'd64, 32'hFFFF_FFFF, rand_texture());
		send_cmd(CMD_RESOLVE, 7'd1, slot_gen[0], '0);
		send_cmd(CMD_RESOLVE, 7'd1, slot_gen[0] + 1'b1, '0);
		send_cmd(CMD_RESOLVE, 7'd64, 32'h0000_0001, '0);
		send_cmd(CMD_DESTROY, 7'd4, 32'h0000_0001, '0);
		send_cmd(CMD_DESTROY, 7'd2, slot_gen[1], '0);
		send_cmd(CMD_DESTROY, 7'd2, slot_gen[1] - 1'b1, '0);
		send_cmd(CMD_RESOLVE, 7'd2, slot_gen[1], '0);
		send_cmd(CMD_CREATE, '0, '0, rand_texture());
		send_cmd(CMD_DESTROY, 7'd3, slot_gen[2], '0);
		send_cmd(CMD_DESTROY, 7'd1, slot_gen[0], '0);
		send_cmd(CMD_CREATE, '0, '0, rand_texture());
		send_cmd(CMD_CREATE, '0, '0, rand_texture());
		send_cmd(CMD_DESTROY, 7'd2, 32'hFFFF_FFFF, '0);
		send_cmd(CMD_DESTROY_ALL, 7'd127 & 7'd63, 32'h5555_AAAA, 32'hAAAA_5555);
		send_cmd(CMD_CREATE, '0, '0, rand_texture());
		send_cmd(CMD_RESOLVE, 7'd63, $urandom, '0);
		send_cmd(CMD_DESTROY_ALL, '0, '0, '0);
	endtask

	// fills every slot, then checks create on a full table and the top slot
	task automatic test_table_full();
		while (used_cnt < SLOTS || free_cnt > 0)
			send_cmd(CMD_CREATE, HANDLE_W'($urandom_range(SLOTS)), $urandom, rand_texture());
		send_cmd(CMD_CREATE, '0, '0, rand_texture());
		send_cmd(CMD_RESOLVE, 7'd64, slot_gen[SLOTS-1], '0);
		send_cmd(CMD_DESTROY, 7'd64, slot_gen[SLOTS-1], '0);
		send_cmd(CMD_DESTROY_ALL, '0, '0, '0);
	endtask

	// mostly valid handles with random payloads, some noise and stale handles
	task automatic test_random();
		int sel;
		int h;
		logic [GEN_W-1:0] g;
		for (int k = 0; k < 125; k++) begin
			steady = (k >= 45 && k < 85);
			sel = $urandom_range(99);
			if (sel < 35) begin
				send_cmd(CMD_CREATE, HANDLE_W'($urandom_range(SLOTS)), $urandom,
					($urandom_range(19) == 0) ? '0 : rand_texture());
			end else if (sel < 75) begin
				h = pick_live();
				g = (h > 0) ? slot_gen[h-1] : $urandom;
				send_cmd((sel < 55) ? CMD_DESTROY : CMD_RESOLVE, HANDLE_W'(h), g, $urandom);
			end else if (sel < 93) begin
				h = $urandom_range(SLOTS);
				case ($urandom_range(2))
				0:       g = $urandom;
				1:       g = (h > 0) ? slot_gen[h-1] - 1'b1 : $urandom;
				default: g = (h > 0) ? slot_gen[h-1] : $urandom;
				endcase
				send_cmd($urandom_range(1) ? CMD_DESTROY : CMD_RESOLVE, HANDLE_W'(h), g,
					$urandom);
			end else begin
				send_cmd(CMD_DESTROY_ALL, HANDLE_W'($urandom_range(SLOTS)), $urandom, $urandom);
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_table_full();
		test_random();
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("ran %0d creates, %0d destroys, %0d resolves, %0d destroy-alls",
			cmd_count[CMD_CREATE], cmd_count[CMD_DESTROY], cmd_count[CMD_RESOLVE],
			cmd_count[CMD_DESTROY_ALL]);
		$display("checked %0d results, %0d faults", results_checked, faults);
		if (faults == 0 && awaited_results.size() == 0) begin
			$display("generational_handle_slot_allocator_core: match");
		end else begin
			$display("generational_handle_slot_allocator_core: mismatch");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout with %0d results outstanding", awaited_results.size());
		$display("generational_handle_slot_allocator_core: mismatch");
		$finish;
	end

endmodule
